// ===== src/cau_pkg.sv =====
// Package for the complex arithmetic unit: port payload types, operation and
// status codes, and the queue item passed from the front end to the back end.
// No dependencies.
package cau_pkg;

	localparam int DW     = 32;
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_CDIV, OP_RDIV, OP_NEG, OP_CONJ, OP_MAG
	} op_t;

	typedef enum logic [1:0] {
		ST_OK, ST_DIV0, ST_SAT
	} status_t;

	typedef enum logic [1:0] {
		CLS_LIN, CLS_MUL, CLS_DIV, CLS_SQRT
	} cls_t;

	typedef struct packed {
		logic [2:0]             operation;
		logic signed [DW-1:0]   a_re;
		logic signed [DW-1:0]   a_im;
		logic signed [DW-1:0]   b_re;
		logic signed [DW-1:0]   b_im;
		logic signed [DW-1:0]   divisor;
	} cau_in_t;

	typedef struct packed {
		logic signed [DW-1:0]   res_re;
		logic signed [DW-1:0]   res_im;
		logic [1:0]             status;
	} cau_out_t;

	typedef struct packed {
		op_t                    op;
		cls_t                   cls;
		logic signed [DW-1:0]   a_re;
		logic signed [DW-1:0]   a_im;
		logic signed [DW-1:0]   b_re;
		logic signed [DW-1:0]   b_im;
		logic signed [DW-1:0]   dv;
	} item_t;

endpackage

// ===== src/cau_front.sv =====
// Front end: accepts commands, trims operands to the word size and classifies
// the operation for the back end. Depends on cau_pkg.
module cau_front #(
	parameter int WB = 32
) (
	input  logic             start,
	input  logic             full,
	input  cau_pkg::cau_in_t cmd,
	output logic             push,
	output cau_pkg::item_t   item
);
	import cau_pkg::*;

	localparam int SH = DW - WB;

	function automatic logic signed [DW-1:0] sext(input logic [DW-1:0] f);
		logic [DW-1:0] t;
		t = f << SH;
		return $signed(t) >>> SH;
	endfunction

	assign push = start && !full;

	always_comb begin
		item.op   = op_t'(cmd.operation);
		item.a_re = sext(cmd.a_re);
		item.a_im = sext(cmd.a_im);
		item.b_re = sext(cmd.b_re);
		item.b_im = sext(cmd.b_im);
		item.dv   = sext(cmd.divisor);
		case (op_t'(cmd.operation))
			OP_MUL:  item.cls = CLS_MUL;
			OP_CDIV: item.cls = CLS_DIV;
			OP_RDIV: item.cls = CLS_DIV;
			OP_MAG:  item.cls = CLS_SQRT;
			default: item.cls = CLS_LIN;
		endcase
	end

endmodule

// ===== src/cau_queue.sv =====
// Short queue between front and back end.
// Depends on cau_pkg.
module cau_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cau_pkg::item_t wdata,
	input  logic           pop,
	output cau_pkg::item_t rdata,
	output logic           full,
	output logic           empty
);
	import cau_pkg::*;

	item_t           ent_q [QDEPTH];
	logic [QPW-1:0]  wp_q, rp_q;
	logic [QPW:0]    cnt_q;

	assign full  = (cnt_q == (QPW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!push && !pop) |=> $stable(cnt_q)) else $error("queue count drifted");

endmodule

// ===== src/cau_back.sv =====
// Back end: product stage, direct result path, and a serial divider and
// square-root unit (one bit per cycle). Depends on cau_pkg.
module cau_back #(
	parameter int WB = 32,
	parameter int FB = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  cau_pkg::item_t   head,
	output logic             pop,
	output logic             done,
	output cau_pkg::cau_out_t result
);
	import cau_pkg::*;

	localparam int PW    = 2 * DW;
	localparam int SW    = PW + 2;
	localparam int NW    = 96;
	localparam int NSTEP = 2 * WB + FB;
	localparam int CW    = $clog2(NSTEP + 1);
	localparam int RTW   = DW + 4;

	function automatic logic [DW:0] sat_word(input logic neg, input logic [NW-1:0] mag);
		logic [NW-1:0] lim;
		logic [NW-1:0] v;
		logic          f;
		lim = NW'(1) << (WB - 1);
		f   = 1'b0;
		if (neg) begin
			if (mag > lim) begin
				f = 1'b1;
				v = -lim;
			end else begin
				v = -mag;
			end
		end else begin
			if (mag > lim - 1'b1) begin
				f = 1'b1;
				v = lim - 1'b1;
			end else begin
				v = mag;
			end
		end
		return {f, v[DW-1:0]};
	endfunction

	function automatic logic [DW:0] zpart(input logic signed [DW-1:0] v);
		if (v > 0) return sat_word(1'b0, NW'(1) << WB);
		else if (v < 0) return sat_word(1'b1, NW'(1) << WB);
		else return '0;
	endfunction

	// product stage
	item_t                 it_s1;
	logic                  v_s1;
	logic signed [PW-1:0]  p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic signed [DW-1:0]  sq4, sq5;

	// serial unit
	logic                  busy_q;
	cls_t                  kind_q;
	logic [CW-1:0]         cnt_q;
	logic [NW-1:0]         n_re_q, n_im_q, q_re_q, q_im_q;
	logic [SW-1:0]         den_q, rem_re_q, rem_im_q;
	logic                  neg_re_q, neg_im_q;
	logic [PW-1:0]         x_q;
	logic [RTW-1:0]        rsq_q;
	logic [DW-1:0]         root_q;

	logic                  done_q;
	cau_out_t              res_q;

	logic                  s1_go, direct, load, fin;
	logic [CW-1:0]         steps;
	logic signed [DW:0]    lre, lim_s;
	logic signed [SW-1:0]  sre, sim;
	logic [SW-1:0]         are, aim, den;
	logic [DW:0]           wre, wim;
	logic                  zd;
	cau_out_t              dres;
	logic [SW-1:0]         t_re, t_im;
	logic [RTW-1:0]        t_sq, trial;
	logic [DW:0]           fre, fim;
	cau_out_t              fres;

	assign sq4 = (head.op == OP_MAG) ? head.a_re : head.b_re;
	assign sq5 = (head.op == OP_MAG) ? head.a_im : head.b_im;

	assign s1_go = v_s1 && !busy_q;
	assign pop   = !empty && (!v_s1 || s1_go);

	always_ff @(posedge clk) begin
		if (pop) begin
			it_s1 <= head;
			p0_s1 <= PW'(head.a_re) * PW'(head.b_re);
			p1_s1 <= PW'(head.a_im) * PW'(head.b_im);
			p2_s1 <= PW'(head.a_re) * PW'(head.b_im);
			p3_s1 <= PW'(head.a_im) * PW'(head.b_re);
			p4_s1 <= PW'(sq4) * PW'(sq4);
			p5_s1 <= PW'(sq5) * PW'(sq5);
		end
	end

	always_comb begin
		case (it_s1.op)
			OP_ADD: begin
				lre   = (DW+1)'(it_s1.a_re) + (DW+1)'(it_s1.b_re);
				lim_s = (DW+1)'(it_s1.a_im) + (DW+1)'(it_s1.b_im);
			end
			OP_SUB: begin
				lre   = (DW+1)'(it_s1.a_re) - (DW+1)'(it_s1.b_re);
				lim_s = (DW+1)'(it_s1.a_im) - (DW+1)'(it_s1.b_im);
			end
			OP_NEG: begin
				lre   = -($signed({it_s1.a_re[DW-1], it_s1.a_re}));
				lim_s = -($signed({it_s1.a_im[DW-1], it_s1.a_im}));
			end
			default: begin
				lre   = $signed({it_s1.a_re[DW-1], it_s1.a_re});
				lim_s = -($signed({it_s1.a_im[DW-1], it_s1.a_im}));
			end
		endcase
		if (it_s1.op == OP_MUL) begin
			sre = SW'(p0_s1) - SW'(p1_s1);
			sim = SW'(p2_s1) + SW'(p3_s1);
		end else if (it_s1.op == OP_CDIV) begin
			sre = SW'(p0_s1) + SW'(p1_s1);
			sim = SW'(p3_s1) - SW'(p2_s1);
		end else begin
			sre = SW'(it_s1.a_re);
			sim = SW'(it_s1.a_im);
		end
		are = (sre < 0) ? SW'(-sre) : SW'(sre);
		aim = (sim < 0) ? SW'(-sim) : SW'(sim);
		if (it_s1.op == OP_CDIV) den = SW'($unsigned(p4_s1)) + SW'($unsigned(p5_s1));
		else den = (it_s1.dv < 0) ? SW'(-SW'(it_s1.dv)) : SW'(it_s1.dv);
		zd = (it_s1.cls == CLS_DIV) && (den == '0);
		if (it_s1.cls == CLS_MUL) begin
			wre = sat_word(sre < 0, NW'(are >> FB));
			wim = sat_word(sim < 0, NW'(aim >> FB));
		end else if (zd) begin
			wre = zpart(it_s1.a_re);
			wim = zpart(it_s1.a_im);
		end else begin
			wre = sat_word(lre < 0, NW'($unsigned((lre < 0) ? -lre : lre)));
			wim = sat_word(lim_s < 0, NW'($unsigned((lim_s < 0) ? -lim_s : lim_s)));
		end
		dres.res_re = wre[DW-1:0];
		dres.res_im = wim[DW-1:0];
		if (zd) dres.status = ST_DIV0;
		else if (wre[DW] || wim[DW]) dres.status = ST_SAT;
		else dres.status = ST_OK;
		direct = (it_s1.cls == CLS_LIN) || (it_s1.cls == CLS_MUL) || zd;
		load   = s1_go && !direct;
	end

	assign steps = (kind_q == CLS_DIV) ? CW'(NSTEP) : CW'(WB);
	assign fin   = busy_q && (cnt_q == steps);

	always_comb begin
		t_re  = {rem_re_q[SW-2:0], n_re_q[NW-1]};
		t_im  = {rem_im_q[SW-2:0], n_im_q[NW-1]};
		t_sq  = {rsq_q[RTW-3:0], x_q[PW-1:PW-2]};
		trial = {2'b00, root_q, 2'b01};
		if (kind_q == CLS_DIV) begin
			fre = sat_word(neg_re_q, q_re_q);
			fim = sat_word(neg_im_q, q_im_q);
		end else begin
			fre = sat_word(1'b0, NW'(root_q));
			fim = '0;
		end
		fres.res_re = fre[DW-1:0];
		fres.res_im = fim[DW-1:0];
		fres.status = (fre[DW] || fim[DW]) ? ST_SAT : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (pop) v_s1 <= 1'b1;
			else if (s1_go) v_s1 <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
			done_q <= fin || (s1_go && direct);
		end
	end

	always_ff @(posedge clk) begin
		if (fin) res_q <= fres;
		else if (s1_go && direct) res_q <= dres;
		if (load) begin
			kind_q   <= it_s1.cls;
			n_re_q   <= NW'(are) << (NW - 2 * WB);
			n_im_q   <= NW'(aim) << (NW - 2 * WB);
			q_re_q   <= '0;
			q_im_q   <= '0;
			rem_re_q <= '0;
			rem_im_q <= '0;
			den_q    <= den;
			if (it_s1.op == OP_RDIV) begin
				neg_re_q <= (it_s1.a_re < 0) != (it_s1.dv < 0);
				neg_im_q <= (it_s1.a_im < 0) != (it_s1.dv < 0);
			end else begin
				neg_re_q <= sre < 0;
				neg_im_q <= sim < 0;
			end
			x_q    <= ($unsigned(p4_s1) + $unsigned(p5_s1)) << (PW - 2 * WB);
			rsq_q  <= '0;
			root_q <= '0;
		end else if (busy_q && !fin) begin
			n_re_q <= n_re_q << 1;
			n_im_q <= n_im_q << 1;
			if (t_re >= den_q) begin
				rem_re_q <= t_re - den_q;
				q_re_q   <= {q_re_q[NW-2:0], 1'b1};
			end else begin
				rem_re_q <= t_re;
				q_re_q   <= {q_re_q[NW-2:0], 1'b0};
			end
			if (t_im >= den_q) begin
				rem_im_q <= t_im - den_q;
				q_im_q   <= {q_im_q[NW-2:0], 1'b1};
			end else begin
				rem_im_q <= t_im;
				q_im_q   <= {q_im_q[NW-2:0], 1'b0};
			end
			x_q <= x_q << 2;
			if (t_sq >= trial) begin
				rsq_q  <= t_sq - trial;
				root_q <= {root_q[DW-2:0], 1'b1};
			end else begin
				rsq_q  <= t_sq;
				root_q <= {root_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> !busy_q) else $error("serial unit still busy after finish");
	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(fin && s1_go)) else $error("two result sources in one cycle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= steps)) else $error("step counter overran");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && cnt_q == '0)) else $error("serial unit failed to start");

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Complex arithmetic unit, Q16.16 by default. Add, sub, mul, negate, conjugate and
// division by zero go from the queue through the product stage to the result
// register; divisions and magnitude go through the serial unit (one bit a cycle).
// Throughput: one item per cycle except behind a division or magnitude; busy is
// high while the four-entry queue is full. The receiver cannot stall.
// Reset (arst_n, asynchronous) clears control state only.
module complex_arithmetic_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cau_pkg::cau_in_t  cmd,
	output logic              done,
	output cau_pkg::cau_out_t result
);
	import cau_pkg::*;

	localparam int WB = (WORD_BITS > DW) ? DW : WORD_BITS;
	localparam int FB = (FRAC_BITS < WB) ? FRAC_BITS : WB - 1;

	logic  push, pop, full, empty;
	item_t fitem, head;

	assign busy = full;

	cau_front #(.WB(WB)) u_front (
		.start (start),
		.full  (full),
		.cmd   (cmd),
		.push  (push),
		.item  (fitem)
	);

	cau_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fitem),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	cau_back #(.WB(WB), .FB(FB)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule
